/* rtl/gtm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared types and constants of the guarded torque mode mux: sizes, command
// and register codes, reset values and the row and request types.
// ----------------------------------------------------------------------------
package gtm_pkg;

    localparam int WHEELS         = 4;
    localparam int MODES          = 4;
    localparam int LIMIT_LEVELS   = 3;
    localparam int DIAL_POSITIONS = 6;

    // Fixed widths of the payload and registers
    localparam int WHEEL_PORTS = 4;
    localparam int VAL_W       = 16;
    localparam int MODE_W      = 2;
    localparam int LEVEL_W     = 2;
    localparam int DIAL_W      = 3;
    localparam int TIME_W      = 32;
    localparam int MAP_W       = 12;
    localparam int SPEED_W     = 15;
    localparam int DELTA_W     = 16;
    localparam int DEBOUNCE_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIAL_MAP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd3;

    // Register reset values
    localparam logic [MAP_W-1:0]      RST_DIAL_MAP    = 12'd0;
    localparam logic [SPEED_W-1:0]    RST_SPEED_LIMIT = 15'd32767;
    localparam logic [DELTA_W-1:0]    RST_DELTA_LIMIT = 16'd50;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE    = 16'd100;

    typedef logic [VAL_W-1:0] t_row [WHEEL_PORTS];

    typedef struct packed {
        logic [SPEED_W-1:0] speed_limit;
        logic [DELTA_W-1:0] delta_limit;
    } t_guard_cfg;

    typedef struct packed {
        logic                  command;
        logic [MODE_W-1:0]     controller_index;
        logic [WHEEL_PORTS-1:0][VAL_W-1:0] wheel_value;
        logic [TIME_W-1:0]     time_ms;
        logic                  tick_50hz;
        logic                  tick_100hz;
        logic                  button_pressed;
        logic [DIAL_W-1:0]     dial_position;
    } t_req;

endpackage

/* rtl/gtm_guard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_guard
// Mode change interlock: blocks a switch when any wheel speed reaches the
// speed limit or any wheel's setpoint step exceeds the delta limit.
// ----------------------------------------------------------------------------
module gtm_guard (
    input  gtm_pkg::t_row       i_active_row,
    input  gtm_pkg::t_row       i_want_row,
    input  gtm_pkg::t_row       i_speed,
    input  gtm_pkg::t_guard_cfg i_cfg,
    output logic                o_blocked
);
    import gtm_pkg::*;

    logic signed [VAL_W:0] w_diff [WHEEL_PORTS];
    logic        [VAL_W:0] w_mag  [WHEEL_PORTS];
    logic [WHEEL_PORTS-1:0] w_hit;

    always_comb begin
        for (int w = 0; w < WHEEL_PORTS; w++) begin
            w_diff[w] = $signed({i_active_row[w][VAL_W-1], i_active_row[w]})
                      - $signed({i_want_row[w][VAL_W-1], i_want_row[w]});
            w_mag[w]  = w_diff[w][VAL_W] ? (VAL_W+1)'(-w_diff[w]) : w_diff[w];
            w_hit[w]  = 1'b0;
            if (w < WHEELS) begin
                // speeds are signed, so reverse rotation never blocks
                w_hit[w] = ($signed({i_speed[w][VAL_W-1], i_speed[w]})
                            >= $signed({2'b00, i_cfg.speed_limit}))
                        || (w_mag[w] > {1'b0, i_cfg.delta_limit});
            end
        end
    end

    assign o_blocked = |w_hit;

endmodule

/* rtl/guarded_torque_mode_mux_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guarded_torque_mode_mux_unit
// Per-mode torque setpoint table with a guarded mode switch on 100 Hz ticks
// and a debounced torque-limit level button on 50 Hz ticks.
// ----------------------------------------------------------------------------
// One request is taken per clock while the output is not stalled, and each
// gives one result. The request sits in an input register, one pass of logic
// updates the state, and the result is the state registers themselves, held
// while the output is stalled; the input register can still take one request
// meanwhile and then stalls the input.
// The active mode's row is mirrored in its own register, so the only table
// read per request is the row of the requested mode.
module guarded_torque_mode_mux_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gtm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gtm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_command,
    input  logic [gtm_pkg::MODE_W-1:0]         i_controller_index,
    input  logic signed [gtm_pkg::VAL_W-1:0]   i_wheel_value_0,
    input  logic signed [gtm_pkg::VAL_W-1:0]   i_wheel_value_1,
    input  logic signed [gtm_pkg::VAL_W-1:0]   i_wheel_value_2,
    input  logic signed [gtm_pkg::VAL_W-1:0]   i_wheel_value_3,
    input  logic [gtm_pkg::TIME_W-1:0]         i_time_ms,
    input  logic                               i_tick_50hz,
    input  logic                               i_tick_100hz,
    input  logic                               i_button_pressed,
    input  logic [gtm_pkg::DIAL_W-1:0]         i_dial_position,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [gtm_pkg::VAL_W-1:0]   o_drive_torque_0,
    output logic signed [gtm_pkg::VAL_W-1:0]   o_drive_torque_1,
    output logic signed [gtm_pkg::VAL_W-1:0]   o_drive_torque_2,
    output logic signed [gtm_pkg::VAL_W-1:0]   o_drive_torque_3,
    output logic [gtm_pkg::MODE_W-1:0]         o_active_mode,
    output logic [gtm_pkg::LEVEL_W-1:0]        o_torque_limit_level
);
    import gtm_pkg::*;

    // configuration
    logic [MAP_W-1:0]      r_dial_map;
    logic [SPEED_W-1:0]    r_speed_limit;
    logic [DELTA_W-1:0]    r_delta_limit;
    logic [DEBOUNCE_W-1:0] r_debounce;

    // request register
    t_req r_req;
    logic r_req_valid;
    logic w_accept;
    logic w_advance;

    // state
    t_row                r_table [MODES];
    t_row                r_active_row;
    t_row                r_drive;
    logic [MODE_W-1:0]   r_active_mode;
    logic [LEVEL_W-1:0]  r_level;
    logic                r_button_last;
    logic [TIME_W-1:0]   r_last_time;
    logic                r_out_valid;

    t_row                n_table [MODES];
    t_row                n_active_row;
    t_row                n_drive;
    logic [MODE_W-1:0]   n_active_mode;
    logic [LEVEL_W-1:0]  n_level;
    logic                n_button_last;
    logic [TIME_W-1:0]   n_last_time;

    t_row                w_vals;
    t_row                w_want_row;
    logic [MODE_W-1:0]   w_want;
    logic                w_switch_req;
    logic                w_blocked;
    logic [TIME_W-1:0]   w_elapsed;
    t_guard_cfg          w_guard_cfg;

    // ---------------- handshake ----------------
    assign w_advance  = r_req_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_req_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_req_valid <= 1'b1;
            end else if (w_advance) begin
                r_req_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.command          <= i_command;
            r_req.controller_index <= i_controller_index;
            r_req.wheel_value      <= {i_wheel_value_3, i_wheel_value_2,
                                       i_wheel_value_1, i_wheel_value_0};
            r_req.time_ms          <= i_time_ms;
            r_req.tick_50hz        <= i_tick_50hz;
            r_req.tick_100hz       <= i_tick_100hz;
            r_req.button_pressed   <= i_button_pressed;
            r_req.dial_position    <= i_dial_position;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dial_map    <= RST_DIAL_MAP;
            r_speed_limit <= RST_SPEED_LIMIT;
            r_delta_limit <= RST_DELTA_LIMIT;
            r_debounce    <= RST_DEBOUNCE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DIAL_MAP:    r_dial_map    <= i_cfg_wdata[MAP_W-1:0];
                REG_SPEED_LIMIT: r_speed_limit <= i_cfg_wdata[SPEED_W-1:0];
                REG_DELTA_LIMIT: r_delta_limit <= i_cfg_wdata[DELTA_W-1:0];
                REG_DEBOUNCE:    r_debounce    <= i_cfg_wdata[DEBOUNCE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- mode request and guard ----------------
    always_comb begin
        for (int w = 0; w < WHEEL_PORTS; w++) begin
            w_vals[w] = r_req.wheel_value[w];
        end
    end

    assign w_want       = r_dial_map[{r_req.dial_position, 1'b0} +: MODE_W];
    assign w_want_row   = r_table[w_want];
    assign w_switch_req = (r_req.dial_position < DIAL_W'(DIAL_POSITIONS))
                       && ({1'b0, w_want} < (MODE_W+1)'(MODES))
                       && (w_want != r_active_mode);
    assign w_elapsed    = r_req.time_ms - r_last_time;

    assign w_guard_cfg.speed_limit = r_speed_limit;
    assign w_guard_cfg.delta_limit = r_delta_limit;

    gtm_guard u_guard (
        .i_active_row (r_active_row),
        .i_want_row   (w_want_row),
        .i_speed      (w_vals),
        .i_cfg        (w_guard_cfg),
        .o_blocked    (w_blocked)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_table       = r_table;
        n_active_row  = r_active_row;
        n_drive       = r_drive;
        n_active_mode = r_active_mode;
        n_level       = r_level;
        n_button_last = r_button_last;
        n_last_time   = r_last_time;

        if (r_req.command == CMD_WRITE) begin
            if ({1'b0, r_req.controller_index} < (MODE_W+1)'(MODES)) begin
                for (int w = 0; w < WHEELS; w++) begin
                    n_table[r_req.controller_index][w] = w_vals[w];
                    // keep the mirror of the active row current
                    if (r_req.controller_index == r_active_mode) begin
                        n_active_row[w] = w_vals[w];
                    end
                end
            end
        end else begin
            if (r_req.tick_50hz) begin
                if (r_button_last && !r_req.button_pressed
                        && (w_elapsed > {{(TIME_W-DEBOUNCE_W){1'b0}}, r_debounce})) begin
                    n_level     = (r_level == LEVEL_W'(LIMIT_LEVELS - 1))
                                ? '0 : r_level + 1'b1;
                    n_last_time = r_req.time_ms;
                end
                n_button_last = r_req.button_pressed;
            end
            if (r_req.tick_100hz) begin
                if (w_switch_req && !w_blocked) begin
                    n_active_mode = w_want;
                    n_active_row  = w_want_row;
                end
                n_drive = n_active_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MODES; m++) begin
                for (int w = 0; w < WHEEL_PORTS; w++) begin
                    r_table[m][w] <= '0;
                end
            end
            for (int w = 0; w < WHEEL_PORTS; w++) begin
                r_active_row[w] <= '0;
                r_drive[w]      <= '0;
            end
            r_active_mode <= '0;
            r_level       <= '0;
            r_button_last <= 1'b0;
            r_last_time   <= '0;
        end else if (w_advance) begin
            r_table       <= n_table;
            r_active_row  <= n_active_row;
            r_drive       <= n_drive;
            r_active_mode <= n_active_mode;
            r_level       <= n_level;
            r_button_last <= n_button_last;
            r_last_time   <= n_last_time;
        end
    end

    // ---------------- result ----------------
    assign o_out_valid          = r_out_valid;
    assign o_drive_torque_0     = r_drive[0];
    assign o_drive_torque_1     = r_drive[1];
    assign o_drive_torque_2     = r_drive[2];
    assign o_drive_torque_3     = r_drive[3];
    assign o_active_mode        = r_active_mode;
    assign o_torque_limit_level = r_level;

endmodule

/* rtl/gtm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtm_checker
// Port-level checks of the guarded torque mode mux: result hold, stall
// cause, result timing and level range.
// ----------------------------------------------------------------------------
module gtm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [gtm_pkg::VAL_W-1:0]   o_drive_torque_0,
    input logic [gtm_pkg::MODE_W-1:0]         o_active_mode,
    input logic [gtm_pkg::LEVEL_W-1:0]        o_torque_limit_level
);
    import gtm_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_drive_torque_0) && $stable(o_active_mode)
             && $stable(o_torque_limit_level)))
        else $error("stalled result changed");

    // the input side stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // a fresh result follows from a taken request
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a request");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_torque_limit_level} < (LEVEL_W+1)'(LIMIT_LEVELS)))
        else $error("torque limit level out of range");

endmodule

bind guarded_torque_mode_mux_unit gtm_checker u_gtm_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_stall           (o_in_stall),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_drive_torque_0     (o_drive_torque_0),
    .o_active_mode        (o_active_mode),
    .o_torque_limit_level (o_torque_limit_level)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives setpoint-row writes and control ticks into the guarded torque mode
// mux under several register settings, predicts every result in a local
// model of the mode table, button debounce and guarded switch, and checks
// each output field in order with random idling on both handshakes.
// ----------------------------------------------------------------------------
module testbench;
    import gtm_pkg::*;

    typedef struct packed {
        logic [WHEEL_PORTS-1:0][VAL_W-1:0] torque;
        logic [MODE_W-1:0]                 mode;
        logic [LEVEL_W-1:0]                level;
    } t_drive_state;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DIAL_MAP;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic in_valid  = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    t_req cur_req   = '0;

    logic signed [VAL_W-1:0] drive_0, drive_1, drive_2, drive_3;
    logic [MODE_W-1:0]       mode_out;
    logic [LEVEL_W-1:0]      level_out;

    // Local copy of the block's state and registers
    logic signed [VAL_W-1:0] torque_rows [MODES][WHEEL_PORTS];
    logic signed [VAL_W-1:0] latched_torque [WHEEL_PORTS];
    logic [MODE_W-1:0]       mode_now        = '0;
    logic [LEVEL_W-1:0]      level_now       = '0;
    logic                    button_was      = 1'b0;
    logic [TIME_W-1:0]       last_release_ms = '0;
    logic [MAP_W-1:0]        dial_cfg        = RST_DIAL_MAP;
    logic [SPEED_W-1:0]      speed_cfg       = RST_SPEED_LIMIT;
    logic [DELTA_W-1:0]      delta_cfg       = RST_DELTA_LIMIT;
    logic [DEBOUNCE_W-1:0]   debounce_cfg    = RST_DEBOUNCE;

    t_req         request_queue [$];
    t_drive_state predicted_drive [$];

    int   send_gap     = 0;
    int   stall_left   = 0;
    int   long_hold    = 0;
    int   results_seen = 0;
    int   mismatches   = 0;
    logic settle_phase = 1'b0;

    logic [TIME_W-1:0] gen_ms  = '0;
    logic              gen_btn = 1'b0;

    guarded_torque_mode_mux_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_index          (cfg_index),
        .i_cfg_wdata          (cfg_wdata),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_command            (cur_req.command),
        .i_controller_index   (cur_req.controller_index),
        .i_wheel_value_0      (cur_req.wheel_value[0]),
        .i_wheel_value_1      (cur_req.wheel_value[1]),
        .i_wheel_value_2      (cur_req.wheel_value[2]),
        .i_wheel_value_3      (cur_req.wheel_value[3]),
        .i_time_ms            (cur_req.time_ms),
        .i_tick_50hz          (cur_req.tick_50hz),
        .i_tick_100hz         (cur_req.tick_100hz),
        .i_button_pressed     (cur_req.button_pressed),
        .i_dial_position      (cur_req.dial_position),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_drive_torque_0     (drive_0),
        .o_drive_torque_1     (drive_1),
        .o_drive_torque_2     (drive_2),
        .o_drive_torque_3     (drive_3),
        .o_active_mode        (mode_out),
        .o_torque_limit_level (level_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        for (int m = 0; m < MODES; m++) begin
            for (int w = 0; w < WHEEL_PORTS; w++) begin
                torque_rows[m][w] = '0;
            end
        end
        for (int w = 0; w < WHEEL_PORTS; w++) begin
            latched_torque[w] = '0;
        end
    end

    // Advance the local model by one request and queue the result it shows
    task automatic compute_drive_state(input t_req r);
        t_drive_state      snap;
        logic [MODE_W-1:0] want;
        logic [TIME_W-1:0] since;
        logic              blocked;
        int                spd;
        int                diff;
        int                dial_i;
        snap = '0;
        if (r.command == CMD_WRITE) begin
            if (r.controller_index < MODES) begin
                for (int w = 0; w < WHEELS; w++) begin
                    torque_rows[r.controller_index][w] = r.wheel_value[w];
                end
            end
        end else begin
            if (r.tick_50hz) begin
                since = r.time_ms - last_release_ms;
                if (button_was && !r.button_pressed && since > TIME_W'(debounce_cfg)) begin
                    level_now       = LEVEL_W'((int'(level_now) + 1) % LIMIT_LEVELS);
                    last_release_ms = r.time_ms;
                end
                button_was = r.button_pressed;
            end
            if (r.tick_100hz) begin
                dial_i = int'(r.dial_position);
                if (dial_i < DIAL_POSITIONS) begin
                    want = dial_cfg[2*dial_i +: MODE_W];
                    if (want < MODES && want != mode_now) begin
                        blocked = 1'b0;
                        for (int w = 0; w < WHEELS; w++) begin
                            spd = $signed(r.wheel_value[w]);
                            if (spd >= int'(speed_cfg)) blocked = 1'b1;
                            diff = int'(torque_rows[mode_now][w]) - int'(torque_rows[want][w]);
                            if (diff < 0) diff = -diff;
                            if (diff > int'(delta_cfg)) blocked = 1'b1;
                        end
                        if (!blocked) mode_now = want;
                    end
                end
                for (int w = 0; w < WHEELS; w++) begin
                    latched_torque[w] = torque_rows[mode_now][w];
                end
            end
        end
        for (int w = 0; w < WHEELS; w++) begin
            snap.torque[w] = latched_torque[w];
        end
        snap.mode  = mode_now;
        snap.level = level_now;
        predicted_drive.push_back(snap);
    endtask

    always @(posedge i_clk) begin : request_driver
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                compute_drive_state(cur_req);
            end
            // hold a stalled request as it is
            if (!(in_valid && in_stall)) begin
                if (send_gap != 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (!settle_phase && $urandom_range(0, 9) == 0) begin
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 12);
                end else if (request_queue.size() != 0) begin
                    cur_req  <= request_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_drive_state exp_s;
        t_drive_state got_s;
        logic         start_hold;
        start_hold = 1'b0;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            long_hold  <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                got_s.torque[0] = drive_0;
                got_s.torque[1] = drive_1;
                got_s.torque[2] = drive_2;
                got_s.torque[3] = drive_3;
                got_s.mode      = mode_out;
                got_s.level     = level_out;
                if (predicted_drive.size() == 0) begin
                    $display("%0t: unexpected result, mode %0d level %0d",
                             $time, got_s.mode, got_s.level);
                    mismatches++;
                end else begin
                    exp_s = predicted_drive.pop_front();
                    for (int w = 0; w < WHEEL_PORTS; w++) begin
                        if (got_s.torque[w] !== exp_s.torque[w]) begin
                            $display("%0t: wheel %0d torque expected %0d actual %0d", $time,
                                     w, $signed(exp_s.torque[w]), $signed(got_s.torque[w]));
                            mismatches++;
                        end
                    end
                    if (got_s.mode !== exp_s.mode) begin
                        $display("%0t: active mode expected %0d actual %0d",
                                 $time, exp_s.mode, got_s.mode);
                        mismatches++;
                    end
                    if (got_s.level !== exp_s.level) begin
                        $display("%0t: limit level expected %0d actual %0d",
                                 $time, exp_s.level, got_s.level);
                        mismatches++;
                    end
                end
                if (results_seen == 700) start_hold = 1'b1;
                results_seen <= results_seen + 1;
            end
            // one long hold-off so the input side backs up
            if (start_hold) begin
                out_stall <= 1'b1;
                long_hold <= 100;
            end else if (long_hold != 0) begin
                out_stall <= 1'b1;
                long_hold <= long_hold - 1;
            end else if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!settle_phase && $urandom_range(0, 9) == 0) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 12);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [WHEEL_PORTS-1:0][VAL_W-1:0] wheels(int a, int b, int c, int d);
        logic [WHEEL_PORTS-1:0][VAL_W-1:0] v;
        v[0] = VAL_W'(a);
        v[1] = VAL_W'(b);
        v[2] = VAL_W'(c);
        v[3] = VAL_W'(d);
        return v;
    endfunction

    // Write rows carry random noise in the fields they ignore
    function automatic t_req make_write(logic [MODE_W-1:0] row,
                                        logic [WHEEL_PORTS-1:0][VAL_W-1:0] vals);
        t_req r;
        r.command          = CMD_WRITE;
        r.controller_index = row;
        r.wheel_value      = vals;
        r.time_ms          = $urandom;
        r.tick_50hz        = 1'($urandom_range(0, 1));
        r.tick_100hz       = 1'($urandom_range(0, 1));
        r.button_pressed   = 1'($urandom_range(0, 1));
        r.dial_position    = DIAL_W'($urandom_range(0, 7));
        return r;
    endfunction

    function automatic t_req make_tick(logic t50, logic t100, logic btn, logic [DIAL_W-1:0] dial,
                                       logic [TIME_W-1:0] ms,
                                       logic [WHEEL_PORTS-1:0][VAL_W-1:0] speeds);
        t_req r;
        r.command          = CMD_TICK;
        r.controller_index = MODE_W'($urandom_range(0, 3));
        r.wheel_value      = speeds;
        r.time_ms          = ms;
        r.tick_50hz        = t50;
        r.tick_100hz       = t100;
        r.button_pressed   = btn;
        r.dial_position    = dial;
        return r;
    endfunction

    // Mostly nearby setpoints and safe speeds so mode switches get through
    function automatic t_req random_request();
        logic [WHEEL_PORTS-1:0][VAL_W-1:0] vals;
        logic                              is_write;
        is_write = ($urandom_range(0, 3) == 0);
        for (int w = 0; w < WHEEL_PORTS; w++) begin
            if (is_write) begin
                if ($urandom_range(0, 3) == 0) vals[w] = VAL_W'($urandom);
                else vals[w] = VAL_W'($urandom_range(0, 400) - 200);
            end else begin
                case ($urandom_range(0, 15))
                    0:       vals[w] = VAL_W'($urandom);
                    1:       vals[w] = VAL_W'(speed_cfg);
                    2:       vals[w] = VAL_W'(speed_cfg) - 1'b1;
                    default: vals[w] = VAL_W'($urandom_range(0, 3000) - 1500);
                endcase
            end
        end
        if ($urandom_range(0, 49) == 0) gen_ms = $urandom;
        else gen_ms = gen_ms + $urandom_range(0, 40);
        if ($urandom_range(0, 2) == 0) gen_btn = !gen_btn;
        if (is_write) return make_write(MODE_W'($urandom_range(0, 3)), vals);
        return make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gen_btn,
                         DIAL_W'($urandom_range(0, 7)), gen_ms, vals);
    endfunction

    task automatic wait_drained();
        while (request_queue.size() != 0 || in_valid || predicted_drive.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [MAP_W-1:0] map, input logic [SPEED_W-1:0] spd,
                                  input logic [DELTA_W-1:0] dlt,
                                  input logic [DEBOUNCE_W-1:0] deb);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DIAL_MAP;
        cfg_wdata <= CFG_DATA_W'(map);
        @(posedge i_clk);
        cfg_index <= REG_SPEED_LIMIT;
        cfg_wdata <= CFG_DATA_W'(spd);
        @(posedge i_clk);
        cfg_index <= REG_DELTA_LIMIT;
        cfg_wdata <= dlt;
        @(posedge i_clk);
        cfg_index <= REG_DEBOUNCE;
        cfg_wdata <= deb;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        dial_cfg     = map;
        speed_cfg    = spd;
        delta_cfg    = dlt;
        debounce_cfg = deb;
    endtask

    task automatic push_random(input int count);
        for (int n = 0; n < count; n++) begin
            request_queue.push_back(random_request());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // positions 0..5 map to modes 0,1,2,3,1,2
        write_settings(12'h9E4, 15'd32767, 16'd50, 16'd100);
        request_queue.push_back(make_write(2'd1, wheels(32767, -32768, 0, -1)));
        request_queue.push_back(make_write(2'd2, wheels(10, 20, -30, 40)));
        request_queue.push_back(make_write(2'd3, wheels(50, -10, 0, 0)));
        request_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 3'd2, 32'd10, wheels(0, 0, 0, 0)));
        // a wheel at the speed limit blocks, negative speeds never do
        request_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 3'd3, 32'd20,
                                          wheels(0, 0, 32767, 0)));
        request_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 3'd3, 32'd30,
                                          wheels(-32768, -1, 32766, 0)));
        request_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 3'd1, 32'd40, wheels(0, 0, 0, 0)));
        // difference exactly at the delta limit still switches
        request_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 3'd0, 32'd50, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 3'd6, 32'd60, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 3'd7, 32'd70, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 3'd0, 32'd80, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_write(2'd0, wheels(-32768, 32767, -1, 1)));
        request_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 3'd0, 32'd90, wheels(0, 0, 0, 0)));
        // button releases around the debounce boundary and across the time wrap
        request_queue.push_back(make_tick(1'b1, 1'b0, 1'b1, 3'd0, 32'd1000, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 3'd0, 32'd1050, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b1, 1'b0, 1'b1, 3'd0, 32'd1100, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 3'd0, 32'd1150, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b1, 1'b0, 1'b1, 3'd0, 32'd1151, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 3'd0, 32'd1151, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b1, 1'b1, 1'b1, 3'd2, 32'hFFFF_FFF0,
                                          wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 3'd0, 32'hFFFF_FFF0,
                                          wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b1, 1'b0, 1'b1, 3'd0, 32'h20, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 3'd0, 32'h60, wheels(0, 0, 0, 0)));
        request_queue.push_back(make_tick(1'b0, 1'b0, 1'b1, 3'd5, 32'h61,
                                          wheels(-1, 32767, -32768, 1)));
        wait_drained();

        write_settings(MAP_W'($urandom), SPEED_W'($urandom_range(500, 3000)),
                       DELTA_W'($urandom_range(50, 400)), DEBOUNCE_W'($urandom_range(0, 60)));
        push_random(500);
        wait_drained();

        // all positions ask for mode 3; only all-negative speeds get through
        write_settings(12'hFFF, 15'd0, 16'hFFFF, 16'hFFFF);
        push_random(400);
        wait_drained();

        write_settings(12'h000, 15'h7FFF, 16'd0, 16'd0);
        push_random(300);
        wait_drained();

        settle_phase = 1'b1;
        write_settings(MAP_W'($urandom), SPEED_W'($urandom_range(0, 32767)),
                       DELTA_W'($urandom_range(0, 1000)), DEBOUNCE_W'($urandom_range(0, 100)));
        push_random(400);
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && predicted_drive.size() == 0) begin
            $display("guarded_torque_mode_mux_unit: match");
        end else begin
            $display("guarded_torque_mode_mux_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("guarded_torque_mode_mux_unit: mismatch");
        $finish;
    end

endmodule
